// File: src/lqm_pkg.sv
// Shared types, constants and index tables for the linked queue manager.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package lqm_pkg;

    // Pool and queue sizes
    localparam int NUM_ELEMENTS = 64;
    localparam int NUM_QUEUES   = 4;

    // Fixed widths of the transfer fields
    localparam int MODE_W     = 1;
    localparam int QUEUE_ID_W = 2;
    localparam int ELEM_ID_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 7;

    // Internal index and count widths
    localparam int EIDX_W = $clog2(NUM_ELEMENTS);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CNT_W  = $clog2(NUM_ELEMENTS + 1);

    // Number of codes the input index fields can carry
    localparam int ELEM_ID_SPAN  = 2 ** ELEM_ID_W;
    localparam int QUEUE_ID_SPAN = 2 ** QUEUE_ID_W;

    typedef logic [EIDX_W-1:0] elem_idx_t;
    typedef logic [QIDX_W-1:0] queue_idx_t;
    typedef logic [CNT_W-1:0]  count_t;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NOTQ  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK2,
        S_RESULT
    } lqm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture request, issue link reads
        logic exec;     // check and first link write group
        logic link2;    // second link write group of a tail append
        logic result;   // load the output register
    } lqm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_link2;   // append into a non-empty queue
        logic out_free;     // output register can take a result
    } lqm_sts_t;

    // Index wrap tables, built at elaboration
    typedef elem_idx_t  elem_wrap_tab_t  [ELEM_ID_SPAN];
    typedef queue_idx_t queue_wrap_tab_t [QUEUE_ID_SPAN];

    function automatic elem_wrap_tab_t mk_elem_wrap();
        elem_wrap_tab_t tab;
        for (int i = 0; i < ELEM_ID_SPAN; i++)
        begin
            tab[i] = EIDX_W'(i % NUM_ELEMENTS);
        end
        return tab;
    endfunction

    function automatic queue_wrap_tab_t mk_queue_wrap();
        queue_wrap_tab_t tab;
        for (int i = 0; i < QUEUE_ID_SPAN; i++)
        begin
            tab[i] = QIDX_W'(i % NUM_QUEUES);
        end
        return tab;
    endfunction

    localparam elem_wrap_tab_t  ELEM_WRAP  = mk_elem_wrap();
    localparam queue_wrap_tab_t QUEUE_WRAP = mk_queue_wrap();

endpackage

// File: src/lqm_ctrl.sv
// Sequencer of the linked queue manager: walks each request through
// capture, execute, optional second link write and result. Uses lqm_pkg.
`timescale 1ns / 1ps

module lqm_ctrl
    import lqm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  lqm_sts_t sts,
    output lqm_cmd_t cmd
);

    lqm_state_t state_reg;
    lqm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_link2 ? S_LINK2 : S_RESULT;
            end
            S_LINK2:
            begin
                cmd.link2  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // wait here while the previous result is still held
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/lqm_datapath.sv
// Datapath of the linked queue manager: link and owner memories, queue
// head/count registers, status check and output register. Uses lqm_pkg.
`timescale 1ns / 1ps

module lqm_datapath
    import lqm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lqm_cmd_t              cmd,
    output lqm_sts_t              sts,
    input  logic [MODE_W-1:0]     mode,
    input  logic [QUEUE_ID_W-1:0] queue_id,
    input  logic [ELEM_ID_W-1:0]  elem_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [LENGTH_W-1:0]   queue_length,
    output logic [ELEM_ID_W-1:0]  head_elem,
    output logic                  head_valid
);

    // Link and owner memories
    elem_idx_t  next_mem  [NUM_ELEMENTS];
    elem_idx_t  prev_mem  [NUM_ELEMENTS];
    queue_idx_t owner_mem [NUM_ELEMENTS];

    // Per element and per queue state
    logic [NUM_ELEMENTS-1:0] queued_reg;
    count_t                  count_reg [NUM_QUEUES];
    elem_idx_t               head_reg  [NUM_QUEUES];

    // Captured request
    logic [MODE_W-1:0] op_mode_reg;
    queue_idx_t        op_q_reg;
    elem_idx_t         op_e_reg;

    // Registered memory reads
    elem_idx_t  prev_h_rd_reg;
    elem_idx_t  prev_e_rd_reg;
    elem_idx_t  next_e_rd_reg;
    queue_idx_t owner_rd_reg;

    status_t stat_reg;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic [ELEM_ID_W-1:0]  head_out_reg;
    logic                  head_valid_reg;

    queue_idx_t in_q;
    elem_idx_t  in_e;
    count_t     cur_cnt;
    elem_idx_t  cur_head;
    logic       cnt_zero;
    logic       cur_queued;
    status_t    op_stat;
    logic       op_ok;

    logic       nxt_we;
    elem_idx_t  nxt_wa;
    elem_idx_t  nxt_wd;
    logic       prv_we;
    elem_idx_t  prv_wa;
    elem_idx_t  prv_wd;

    assign in_q = QUEUE_WRAP[queue_id];
    assign in_e = ELEM_WRAP[elem_id];

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_mode_reg <= mode;
            op_q_reg    <= in_q;
            op_e_reg    <= in_e;
        end
    end

    // Current view of the targeted queue and element
    assign cur_cnt    = count_reg[op_q_reg];
    assign cur_head   = head_reg[op_q_reg];
    assign cnt_zero   = (cur_cnt == '0);
    assign cur_queued = queued_reg[op_e_reg];

    // Status check; for a remove, empty queue is tested before membership
    always_comb
    begin
        if (op_mode_reg == MODE_APPEND)
        begin
            op_stat = cur_queued ? STAT_DUP : STAT_OK;
        end
        else if (cnt_zero)
        begin
            op_stat = STAT_EMPTY;
        end
        else if (!cur_queued || (owner_rd_reg != op_q_reg))
        begin
            op_stat = STAT_NOTQ;
        end
        else
        begin
            op_stat = STAT_OK;
        end
    end

    assign op_ok = (op_stat == STAT_OK);

    assign sts.need_link2 = op_ok && (op_mode_reg == MODE_APPEND) && !cnt_zero;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Link write selection
    always_comb
    begin
        nxt_we = 1'b0;
        nxt_wa = op_e_reg;
        nxt_wd = op_e_reg;
        prv_we = 1'b0;
        prv_wa = op_e_reg;
        prv_wd = op_e_reg;
        if (cmd.exec && op_ok)
        begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
            if (op_mode_reg == MODE_APPEND)
            begin
                if (!cnt_zero)
                begin
                    // old tail points forward to the new element
                    nxt_wa = prev_h_rd_reg;
                    prv_wd = prev_h_rd_reg;
                end
            end
            else
            begin
                // unlink: neighbors point at each other
                nxt_wa = prev_e_rd_reg;
                nxt_wd = next_e_rd_reg;
                prv_wa = next_e_rd_reg;
                prv_wd = prev_e_rd_reg;
            end
        end
        else if (cmd.link2)
        begin
            // close the ring through the head
            nxt_we = 1'b1;
            nxt_wd = cur_head;
            prv_we = 1'b1;
            prv_wa = cur_head;
        end
    end

    // Memories: one write and registered reads
    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            next_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prev_mem[prv_wa] <= prv_wd;
        end
        if (cmd.exec && op_ok && (op_mode_reg == MODE_APPEND))
        begin
            owner_mem[op_e_reg] <= op_q_reg;
        end
        if (cmd.load)
        begin
            prev_h_rd_reg <= prev_mem[head_reg[in_q]];
            prev_e_rd_reg <= prev_mem[in_e];
            next_e_rd_reg <= next_mem[in_e];
            owner_rd_reg  <= owner_mem[in_e];
        end
    end

    // Membership flags and queue counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (cmd.exec && op_ok)
        begin
            if (op_mode_reg == MODE_APPEND)
            begin
                queued_reg[op_e_reg] <= 1'b1;
                count_reg[op_q_reg]  <= cur_cnt + count_t'(1);
            end
            else
            begin
                queued_reg[op_e_reg] <= 1'b0;
                count_reg[op_q_reg]  <= cur_cnt - count_t'(1);
            end
        end
    end

    // Queue heads and the latched status
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_reg <= op_stat;
            if (op_ok)
            begin
                if (op_mode_reg == MODE_APPEND)
                begin
                    if (cnt_zero)
                    begin
                        head_reg[op_q_reg] <= op_e_reg;
                    end
                end
                else if (cur_head == op_e_reg)
                begin
                    head_reg[op_q_reg] <= next_e_rd_reg;
                end
            end
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            status_reg     <= stat_reg;
            length_reg     <= LENGTH_W'(cur_cnt);
            head_valid_reg <= !cnt_zero;
            head_out_reg   <= cnt_zero ? '0 : ELEM_ID_W'(cur_head);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign queue_length = length_reg;
    assign head_elem    = head_out_reg;
    assign head_valid   = head_valid_reg;

endmodule

// File: src/linked_queue_manager_core.sv
// Top level of the linked queue manager: sequencer plus datapath.
// Depends on lqm_pkg, lqm_ctrl and lqm_datapath.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid/in_stall with mode, queue_id, elem_id.
//   mode 0 appends elem_id at the tail of queue_id, mode 1 removes it from
//   anywhere in that queue. Indexes wrap to the pool and queue counts.
//   Result channel: out_valid/out_stall with status, queue_length,
//   head_elem and head_valid, one result per request, in request order.
// Sequencing
//   One request is in flight at a time. A remove, a refused request or an
//   append into an empty queue goes through capture, execute and result;
//   an append into a non-empty queue adds a second link write step before
//   the result, since each link memory has one write port and a tail append
//   rewrites two entries in each. The result step loads the output register.
// Stall
//   A result waits in the output register while out_stall is high; the next
//   request is still taken and processed, then holds until the register frees.
// Reset
//   rst_n clears the queue counts, membership flags and the output valid;
//   link memories need no clearing, so requests are taken right after reset.

module linked_queue_manager_core
    import lqm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MODE_W-1:0]     mode,
    input  logic [QUEUE_ID_W-1:0] queue_id,
    input  logic [ELEM_ID_W-1:0]  elem_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [LENGTH_W-1:0]   queue_length,
    output logic [ELEM_ID_W-1:0]  head_elem,
    output logic                  head_valid
);

    lqm_cmd_t cmd;
    lqm_sts_t sts;

    // Sequencer
    lqm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Memories, queue state and result register
    lqm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .queue_id     (queue_id),
        .elem_id      (elem_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .queue_length (queue_length),
        .head_elem    (head_elem),
        .head_valid   (head_valid)
    );

    // A transfer is followed by a busy period
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one in flight");

    // Loading a result always presents it next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> out_valid)
        else $error("result load did not raise out_valid");

    // Head flag tracks the reported length
    a_head_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((NUM_ELEMENTS > 127) || (head_valid == (queue_length != '0))))
        else $error("head_valid disagrees with queue_length");

    // Empty queue reports head zero, and an empty status means no head
    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (!head_valid || (status == STAT_EMPTY)))
            |-> (!head_valid && (head_elem == '0)))
        else $error("empty queue result carries a head");

endmodule

// File: tb/tb_linked_queue_manager.sv
// Self-checking testbench for linked_queue_manager_core: directed and random requests,
// with a tracker class that models the linked queues and checks every result transfer.
// Depends on lqm_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb;
    import lqm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_RUN = 360;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 12;

    // Random segment kinds
    typedef enum int {
        SEG_DRAIN,
        SEG_FILL,
        SEG_MIXED,
        SEG_CHURN
    } seg_kind_t;

    // Tracks queue contents and the results each request should produce
    class link_queue_board;
        typedef struct {
            status_t               st;
            logic [LENGTH_W-1:0]   len;
            logic [ELEM_ID_W-1:0]  head;
            logic                  hv;
        } outcome_t;

        int       nxt      [NUM_ELEMENTS];
        int       prv      [NUM_ELEMENTS];
        bit       queued   [NUM_ELEMENTS];
        int       owner    [NUM_ELEMENTS];
        int       q_head   [NUM_QUEUES];
        int       q_count  [NUM_QUEUES];
        outcome_t expected_results[$];
        int       errors;
        int       checked;
        int       seen_status[4];
        int       longest;

        function new();
            for (int i = 0; i < NUM_ELEMENTS; i++)
            begin
                queued[i] = 1'b0;
            end
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                q_count[i] = 0;
            end
            errors  = 0;
            checked = 0;
            longest = 0;
            for (int i = 0; i < 4; i++)
            begin
                seen_status[i] = 0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted request and queue the result it should produce
        function void note_request(logic [MODE_W-1:0] m, logic [QUEUE_ID_W-1:0] qid,
                                   logic [ELEM_ID_W-1:0] eid);
            int       q;
            int       e;
            int       h;
            int       t;
            int       p;
            int       n;
            status_t  st;
            outcome_t x;
            q = int'(qid) % NUM_QUEUES;
            e = int'(eid) % NUM_ELEMENTS;
            if (m == MODE_APPEND)
            begin
                if (queued[e])
                begin
                    st = STAT_DUP;
                end
                else
                begin
                    st = STAT_OK;
                    if (q_count[q] == 0)
                    begin
                        q_head[q] = e;
                        nxt[e] = e;
                        prv[e] = e;
                    end
                    else
                    begin
                        // splice in between the tail and the head
                        h = q_head[q];
                        t = prv[h];
                        nxt[t] = e;
                        prv[e] = t;
                        prv[h] = e;
                        nxt[e] = h;
                    end
                    queued[e] = 1'b1;
                    owner[e]  = q;
                    q_count[q]++;
                end
            end
            else
            begin
                // empty queue is checked before membership
                if (q_count[q] == 0)
                begin
                    st = STAT_EMPTY;
                end
                else if (!queued[e] || owner[e] != q)
                begin
                    st = STAT_NOTQ;
                end
                else
                begin
                    st = STAT_OK;
                    p = prv[e];
                    n = nxt[e];
                    nxt[p] = n;
                    prv[n] = p;
                    if (q_head[q] == e)
                    begin
                        q_head[q] = n;
                    end
                    queued[e] = 1'b0;
                    q_count[q]--;
                end
            end
            x.st   = st;
            x.len  = LENGTH_W'(q_count[q]);
            x.hv   = (q_count[q] != 0);
            x.head = x.hv ? ELEM_ID_W'(q_head[q]) : '0;
            expected_results.push_back(x);
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [STATUS_W-1:0] got_st, logic [LENGTH_W-1:0] got_len,
                          logic [ELEM_ID_W-1:0] got_head, logic got_hv);
            outcome_t x;
            if (expected_results.size() == 0)
            begin
                report("result transfer with no request outstanding");
            end
            else
            begin
                x = expected_results.pop_front();
                checked++;
                if (got_st !== x.st)
                begin
                    report($sformatf("status got %0d want %0d", got_st, x.st));
                end
                if (got_len !== x.len)
                begin
                    report($sformatf("queue_length got %0d want %0d", got_len, x.len));
                end
                if (got_head !== x.head)
                begin
                    report($sformatf("head_elem got %0d want %0d", got_head, x.head));
                end
                if (got_hv !== x.hv)
                begin
                    report($sformatf("head_valid got %0d want %0d", got_hv, x.hv));
                end
                seen_status[x.st]++;
                if (int'(x.len) > longest)
                begin
                    longest = int'(x.len);
                end
            end
        endtask

        // Random unqueued element, or -1 when the pool is used up
        function int pick_free();
            int cand[$];
            for (int i = 0; i < NUM_ELEMENTS; i++)
            begin
                if (!queued[i])
                begin
                    cand.push_back(i);
                end
            end
            if (cand.size() == 0)
            begin
                return -1;
            end
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        // Random element of queue q, or -1 when it is empty
        function int pick_member(int q);
            int cand[$];
            for (int i = 0; i < NUM_ELEMENTS; i++)
            begin
                if (queued[i] && owner[i] == q)
                begin
                    cand.push_back(i);
                end
            end
            if (cand.size() == 0)
            begin
                return -1;
            end
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        function int pick_busy_queue(int fallback);
            int cand[$];
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                if (q_count[i] != 0)
                begin
                    cand.push_back(i);
                end
            end
            if (cand.size() == 0)
            begin
                return fallback;
            end
            return cand[$urandom_range(cand.size() - 1)];
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode;
    logic [QUEUE_ID_W-1:0] queue_id;
    logic [ELEM_ID_W-1:0]  elem_id;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [LENGTH_W-1:0]   queue_length;
    logic [ELEM_ID_W-1:0]  head_elem;
    logic                  head_valid;

    link_queue_board board;
    int              send_idle;
    int              recv_idle;
    int              hold_left;
    int              cycles;
    int              requests_sent;
    seg_kind_t       seg_kind;
    int              seg_left;
    int              focus_q;

    linked_queue_manager_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .queue_id     (queue_id),
        .elem_id      (elem_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .queue_length (queue_length),
        .head_elem    (head_elem),
        .head_valid   (head_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: long hold-off when asked, otherwise random stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // Monitor both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_result(status, queue_length, head_elem, head_valid);
            end
            if (in_valid && !in_stall)
            begin
                board.note_request(mode, queue_id, elem_id);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request; entered and left at a falling edge
    task send_request(logic [MODE_W-1:0] m, logic [QUEUE_ID_W-1:0] q,
                      logic [ELEM_ID_W-1:0] e);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        queue_id <= q;
        elem_id  <= e;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mostly well-formed requests shaped by the current segment, some noise
    function void next_item(output logic [MODE_W-1:0] m, output logic [QUEUE_ID_W-1:0] q,
                            output logic [ELEM_ID_W-1:0] e);
        int app_pct;
        int noise_pct;
        int focus_pct;
        int qi;
        int pick;
        if (seg_left == 0)
        begin
            case (seg_kind)
                SEG_DRAIN: seg_kind = SEG_FILL;
                SEG_FILL:  seg_kind = SEG_MIXED;
                SEG_MIXED: seg_kind = SEG_CHURN;
                default:   seg_kind = SEG_DRAIN;
            endcase
            case (seg_kind)
                SEG_DRAIN: seg_left = 110;
                SEG_FILL:  seg_left = 75;
                SEG_MIXED: seg_left = 90;
                default:   seg_left = 70;
            endcase
            focus_q = $urandom_range(NUM_QUEUES - 1);
        end
        seg_left--;
        case (seg_kind)
            SEG_DRAIN: begin app_pct = 8;   noise_pct = 5;  focus_pct = 0;   end
            SEG_FILL:  begin app_pct = 100; noise_pct = 0;  focus_pct = 100; end
            SEG_MIXED: begin app_pct = 55;  noise_pct = 10; focus_pct = 40;  end
            default:   begin app_pct = 35;  noise_pct = 10; focus_pct = 60;  end
        endcase
        if ($urandom_range(99) < noise_pct)
        begin
            m = ($urandom_range(1) != 0) ? MODE_REMOVE : MODE_APPEND;
            q = QUEUE_ID_W'($urandom_range(3));
            e = ELEM_ID_W'($urandom_range(63));
            return;
        end
        qi = ($urandom_range(99) < focus_pct) ? focus_q : $urandom_range(NUM_QUEUES - 1);
        if ($urandom_range(99) < app_pct)
        begin
            m    = MODE_APPEND;
            pick = board.pick_free();
        end
        else
        begin
            m = MODE_REMOVE;
            if (board.q_count[qi] == 0 && $urandom_range(99) < 80)
            begin
                qi = board.pick_busy_queue(qi);
            end
            pick = board.pick_member(qi);
        end
        q = QUEUE_ID_W'(qi);
        e = (pick < 0) ? ELEM_ID_W'($urandom_range(63)) : ELEM_ID_W'(pick);
    endfunction

    task run_random(int n);
        logic [MODE_W-1:0]     m;
        logic [QUEUE_ID_W-1:0] q;
        logic [ELEM_ID_W-1:0]  e;
        for (int i = 0; i < n; i++)
        begin
            next_item(m, q, e);
            send_request(m, q, e);
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_APPEND;
        queue_id      = '0;
        elem_id       = '0;
        send_idle     = 35;
        recv_idle     = 59;
        hold_left     = 0;
        cycles        = 0;
        requests_sent = 0;
        seg_kind      = SEG_CHURN;
        seg_left      = 0;
        focus_q       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty, duplicate, foreign and unqueued removes, head/middle/tail
        send_request(MODE_REMOVE, 2'd0, 6'd0);
        send_request(MODE_APPEND, 2'd0, 6'd0);
        send_request(MODE_APPEND, 2'd0, 6'd63);
        send_request(MODE_APPEND, 2'd0, 6'd31);
        send_request(MODE_APPEND, 2'd0, 6'd0);
        send_request(MODE_APPEND, 2'd3, 6'd63);
        send_request(MODE_REMOVE, 2'd1, 6'd0);
        send_request(MODE_APPEND, 2'd3, 6'd42);
        send_request(MODE_REMOVE, 2'd0, 6'd42);
        send_request(MODE_REMOVE, 2'd0, 6'd10);
        send_request(MODE_REMOVE, 2'd0, 6'd63);
        send_request(MODE_REMOVE, 2'd0, 6'd0);
        send_request(MODE_APPEND, 2'd0, 6'd5);
        send_request(MODE_APPEND, 2'd0, 6'd6);
        send_request(MODE_REMOVE, 2'd0, 6'd6);
        send_request(MODE_REMOVE, 2'd0, 6'd31);
        send_request(MODE_REMOVE, 2'd0, 6'd5);
        send_request(MODE_REMOVE, 2'd3, 6'd42);
        send_request(MODE_APPEND, 2'd2, 6'd21);
        send_request(MODE_APPEND, 2'd1, 6'd42);
        send_request(MODE_APPEND, 2'd1, 6'd21);
        send_request(MODE_REMOVE, 2'd2, 6'd21);
        send_request(MODE_REMOVE, 2'd1, 6'd42);
        send_request(MODE_REMOVE, 2'd3, 6'd63);
        wait_drained();

        // Random, sender idles less than the receiver
        run_random(ITEMS_PER_RUN);
        wait_drained();

        // Random, profiles swapped
        send_idle = 59;
        recv_idle = 35;
        run_random(ITEMS_PER_RUN);
        wait_drained();

        // No idling; start with a long result hold-off so the input backs up
        send_idle = 0;
        recv_idle = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        run_random(ITEMS_PER_RUN);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (directed, then random fill/drain/churn) under three idling",
                 requests_sent);
        $display("profiles; %0d results: ok %0d dup %0d empty %0d notq %0d, longest queue %0d",
                 board.checked, board.seen_status[STAT_OK], board.seen_status[STAT_DUP],
                 board.seen_status[STAT_EMPTY], board.seen_status[STAT_NOTQ], board.longest);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/lqm_pkg.sv
src/lqm_ctrl.sv
src/lqm_datapath.sv
src/linked_queue_manager_core.sv
tb/tb_linked_queue_manager.sv
